/* rtl/lpmt_pkg.sv */
// Shared types, codes and helpers for the longest prefix match table.
package lpmt_pkg;

    localparam int ADDR_BITS = 32;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_CHK = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BADLEN   = 3'd4;

    // One stored prefix.
    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [5:0]           len;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the item and clear the scan results
        logic rd;      // read the entry at the scan index and step the index
        logic finish;  // update the table and register the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic quick;   // item needs no scan
        logic last;    // scan index is at the final entry
    } t_dp_sts;

    // Mask that keeps the top len bits of an address; len is 0 to 32.
    function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [5:0] len);
        logic [ADDR_BITS-1:0] m;
        if (len == 6'd0) begin
            m = '0;
        end else begin
            m = {ADDR_BITS{1'b1}} << (6'(ADDR_BITS) - len);
        end
        return m;
    endfunction

endpackage

/* rtl/lpmt_ctrl.sv */
// Controller state machine that sequences one table operation.
module lpmt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  lpmt_pkg::t_dp_sts i_sts,
    output lpmt_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);
    import lpmt_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.quick) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // The final read is compared in this cycle.
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/lpmt_dp.sv */
// Datapath: prefix store, valid bits, scan comparator and result registers.
module lpmt_dp #(
    parameter int ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpmt_pkg::t_dp_cmd i_cmd,
    input  logic [1:0]        i_opcode,
    input  logic [31:0]       i_address,
    input  logic [5:0]        i_prefix_len,
    output lpmt_pkg::t_dp_sts o_sts,
    output logic              o_done,
    output logic [2:0]        o_status,
    output logic [5:0]        o_match_len
);
    import lpmt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_entry r_mem [ENTRIES];

    // Captured item.
    logic [1:0]           r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [5:0]           r_len;

    // Scan index and read pipeline.
    logic [IW-1:0] r_idx;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_valid;
    t_entry        r_rd_ent;

    // Scan results.
    logic          r_pair_hit, n_pair_hit;
    logic [IW-1:0] r_pair_slot, n_pair_slot;
    logic          r_free_hit, n_free_hit;
    logic [IW-1:0] r_free_slot, n_free_slot;
    logic          r_pfx_hit, n_pfx_hit;
    logic [5:0]    r_best, n_best;

    // Table state.
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]      r_count;

    // Result.
    logic       r_done;
    logic [2:0] r_status, n_status;
    logic [5:0] r_match_len, n_match_len;

    logic cmp_pair, cmp_pfx, cmp_free;
    logic len_bad, do_add, do_del;

    // A check ignores the length field, so a bad length skips the scan only for add and delete.
    assign len_bad     = (r_len > 6'(ADDR_BITS));
    assign o_sts.quick = (r_op == OP_NOP) || (len_bad && (r_op != OP_CHK));
    assign o_sts.last  = (r_idx == IW'(ENTRIES - 1));

    assign cmp_free = r_rd_vld && !r_rd_valid;
    assign cmp_pair = r_rd_vld && r_rd_valid && (r_rd_ent.base == r_addr)
                      && (r_rd_ent.len == r_len);
    assign cmp_pfx  = r_rd_vld && r_rd_valid
                      && (((r_rd_ent.base ^ r_addr) & prefix_mask(r_rd_ent.len)) == '0);

    always_comb begin
        n_pair_hit  = r_pair_hit;
        n_pair_slot = r_pair_slot;
        n_free_hit  = r_free_hit;
        n_free_slot = r_free_slot;
        n_pfx_hit   = r_pfx_hit;
        n_best      = r_best;
        if (cmp_pair && !r_pair_hit) begin
            n_pair_hit  = 1'b1;
            n_pair_slot = r_rd_idx;
        end
        if (cmp_free && !r_free_hit) begin
            n_free_hit  = 1'b1;
            n_free_slot = r_rd_idx;
        end
        if (cmp_pfx) begin
            n_pfx_hit = 1'b1;
            if (r_rd_ent.len > r_best) begin
                n_best = r_rd_ent.len;
            end
        end
    end

    // Result and table update at finish.
    always_comb begin
        n_status    = ST_NOTFOUND;
        n_match_len = '0;
        do_add      = 1'b0;
        do_del      = 1'b0;
        case (r_op)
            OP_ADD: begin
                if (len_bad) begin
                    n_status = ST_BADLEN;
                end else if (r_pair_hit) begin
                    n_status = ST_DUP;
                end else if (r_count == CW'(ENTRIES)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    do_add   = 1'b1;
                end
            end
            OP_DEL: begin
                if (r_pair_hit) begin
                    n_status = ST_OK;
                    do_del   = 1'b1;
                end
            end
            OP_CHK: begin
                if (r_pfx_hit) begin
                    n_status    = ST_OK;
                    n_match_len = r_best;
                end
            end
            default: begin
                n_status = ST_NOTFOUND;
            end
        endcase
    end

    // Item capture and memory port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_addr <= i_address;
            r_len  <= i_prefix_len;
        end
        if (i_cmd.finish && do_add) begin
            r_mem[r_free_slot] <= '{base: r_addr, len: r_len};
        end
        if (i_cmd.rd) begin
            r_rd_ent   <= r_mem[r_idx];
            r_rd_valid <= r_valid[r_idx];
            r_rd_idx   <= r_idx;
        end
        r_pair_slot <= n_pair_slot;
        r_free_slot <= n_free_slot;
        r_best      <= i_cmd.load ? 6'd0 : n_best;
        r_status    <= n_status;
        r_match_len <= n_match_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_pair_hit <= 1'b0;
            r_free_hit <= 1'b0;
            r_pfx_hit  <= 1'b0;
            r_valid    <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd;
            r_done   <= i_cmd.finish;
            if (i_cmd.load) begin
                r_idx      <= '0;
                r_pair_hit <= 1'b0;
                r_free_hit <= 1'b0;
                r_pfx_hit  <= 1'b0;
            end else begin
                if (i_cmd.rd) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_pair_hit <= n_pair_hit;
                r_free_hit <= n_free_hit;
                r_pfx_hit  <= n_pfx_hit;
            end
            if (i_cmd.finish && do_add) begin
                r_valid[r_free_slot] <= 1'b1;
                r_count              <= r_count + 1'b1;
            end
            if (i_cmd.finish && do_del) begin
                r_valid[r_pair_slot] <= 1'b0;
                r_count              <= r_count - 1'b1;
            end
        end
    end

    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_match_len = r_match_len;

endmodule

/* rtl/longest_prefix_match_table_unit.sv */
// Top level of the IPv4 longest prefix match table.
//
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   i_opcode, i_address, i_prefix_len
// result    out        o_done for one cycle   o_status, o_match_len
//
// An item that needs a scan reads all ENTRIES slots through one comparator,
// one entry per cycle from a memory with a registered read port. An unknown
// opcode, or an add or delete with an over-long prefix length, skips the
// scan. A check always scans, whatever its length field. The next item can
// be accepted in the cycle in which the result is shown. Reset is
// synchronous and active low; it empties the table at once through the
// valid bits, so no clearing pass is needed. Results cannot be stalled.
module longest_prefix_match_table_unit #(
    parameter int ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_len,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [5:0]  o_match_len
);
    import lpmt_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller only steps through load, scan, drain and finish; all
    // table state and the compare logic sit in the datapath.
    lpmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lpmt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_address    (i_address),
        .i_prefix_len (i_prefix_len),
        .o_sts        (sts),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_match_len  (o_match_len)
    );

    // An accepted item keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // One item yields one result, so strobes never come back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // Every finish command of the controller is followed by a result.
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_done)
        else $error("finish command gave no result");

    // A length is reported only for a successful check.
    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_match_len == 6'd0))
        else $error("match length reported with a failing status");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the IPv4 longest prefix match table unit.
`timescale 1ns / 1ps

module testbench;
    import lpmt_pkg::*;

    // The table depth must agree with the instance below.
    localparam int TABLE_DEPTH = 64;
    // Long enough for one scanning item, with a quiet margin on top.
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    // Cycles in which neither an item nor a result is accepted before the run
    // is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Only the first few mismatches are printed; all of them are counted.
    localparam int PRINT_LIMIT = 40;

    // One predicted result, kept together with the item that caused it so
    // that a mismatch can say which operation went wrong.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic [2:0]  status;
        logic [5:0]  mlen;
    } t_lookup_result;

    // A prefix that the stimulus has asked to store; the list is only used to
    // aim deletes, duplicates and checks at entries that are likely present.
    typedef struct {
        logic [31:0] base;
        logic [5:0]  plen;
    } t_prefix;

    // Operation mix of one burst of random items.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    // The scoreboard keeps its own copy of the prefix table, predicts the
    // answer to every accepted item and compares each result strobe with the
    // oldest prediction.
    class prefix_scoreboard;
        bit          slot_used[TABLE_DEPTH];
        logic [31:0] slot_base[TABLE_DEPTH];
        logic [5:0]  slot_len[TABLE_DEPTH];
        t_lookup_result pending_q[$];
        int          errors;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_base[i] = '0;
                slot_len[i]  = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        // Slot that holds exactly this base and length, or -1.
        function int find_prefix(logic [31:0] base, logic [5:0] plen);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_used[i] && slot_base[i] == base && slot_len[i] == plen) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Applies one accepted item to the table copy and queues its answer.
        function void note_command(logic [1:0] op, logic [31:0] addr, logic [5:0] plen);
            t_lookup_result r;
            int slot;
            bit found;
            int sh;
            r.op     = op;
            r.addr   = addr;
            r.plen   = plen;
            r.status = ST_NOTFOUND;
            r.mlen   = '0;
            case (op)
                OP_ADD: begin
                    if (plen > 6'(ADDR_BITS)) begin
                        r.status = ST_BADLEN;
                    end else if (find_prefix(addr, plen) >= 0) begin
                        r.status = ST_DUP;
                    end else begin
                        slot = -1;
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (!slot_used[i] && slot < 0) begin
                                slot = i;
                            end
                        end
                        if (slot < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            slot_used[slot] = 1'b1;
                            slot_base[slot] = addr;
                            slot_len[slot]  = plen;
                            r.status = ST_OK;
                        end
                    end
                end
                OP_DEL: begin
                    slot = (plen > 6'(ADDR_BITS)) ? -1 : find_prefix(addr, plen);
                    if (slot >= 0) begin
                        slot_used[slot] = 1'b0;
                        r.status = ST_OK;
                    end
                end
                OP_CHK: begin
                    found = 1'b0;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot_used[i]) begin
                            sh = ADDR_BITS - int'(slot_len[i]);
                            // A zero length matches every address.
                            if (slot_len[i] == 6'd0 || (slot_base[i] >> sh) == (addr >> sh)) begin
                                if (!found || slot_len[i] > r.mlen) begin
                                    r.mlen = slot_len[i];
                                end
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        r.status = ST_OK;
                    end
                end
                default: begin
                    // An unknown opcode leaves the table alone.
                end
            endcase
            pending_q.push_back(r);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) begin
                $display("MISMATCH at %0t ns: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_result(logic [2:0] status, logic [5:0] mlen);
            t_lookup_result r;
            if (pending_q.size() == 0) begin
                report($sformatf("result status=%0d len=%0d with no item outstanding",
                                 status, mlen));
            end else begin
                r = pending_q.pop_front();
                if (status !== r.status) begin
                    report($sformatf("op=%0d addr=%h len=%0d: status %0d, predicted %0d",
                                     r.op, r.addr, r.plen, status, r.status));
                end
                if (mlen !== r.mlen) begin
                    report($sformatf("op=%0d addr=%h len=%0d: match_len %0d, predicted %0d",
                                     r.op, r.addr, r.plen, mlen, r.mlen));
                end
            end
        endtask

        task report_leftovers();
            while (pending_q.size() > 0) begin
                report($sformatf("op=%0d addr=%h len=%0d never answered",
                                 pending_q[0].op, pending_q[0].addr, pending_q[0].plen));
                void'(pending_q.pop_front());
            end
        endtask
    endclass

    // Clock, reset and every input of the block start at known values.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  i_opcode     = OP_NOP;
    logic [31:0] i_address    = '0;
    logic [5:0]  i_prefix_len = '0;
    logic        busy;
    logic        o_done;
    logic [2:0]  o_status;
    logic [5:0]  o_match_len;

    prefix_scoreboard sb = new();

    // Percentage of items that the sender precedes with an idle gap.
    int          sender_idle_pct = 0;
    // Prefixes the stimulus has tried to add; used to aim later items.
    t_prefix     issued_prefixes[$];
    int          stall_cycles = 0;

    always #10 i_clk = ~i_clk;

    longest_prefix_match_table_unit #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_address   (i_address),
        .i_prefix_len(i_prefix_len),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_match_len (o_match_len)
    );

    // Results cannot be held off, so every strobe is checked at the edge that
    // ends its cycle. The values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            sb.check_result(o_status, o_match_len);
        end
    end

    // Progress monitor: any accepted item or result restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n && ((start && busy === 1'b0) || o_done === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Run stalled for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Presents one item and holds it until the block takes it. The call
    // returns at the accepting edge with start still high, so a following
    // item without a gap simply replaces the payload at that same edge.
    // A gap, when drawn, can be as long as a whole scan, which puts the next
    // request on any cycle of the block's work, including quick items.
    task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                             input logic [5:0] plen);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            gap = $urandom_range(1, TABLE_DEPTH + 6);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_opcode     <= op;
        i_address    <= addr;
        i_prefix_len <= plen;
        start        <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        sb.note_command(op, addr, plen);
    endtask

    // Drops start and waits until every predicted result has been seen,
    // then lets the block settle for one more scan length.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Draws one random item with the given operation mix. Most deletes and
    // checks are aimed at prefixes that were added earlier, so that hits,
    // nested matches and duplicates are common rather than rare.
    task automatic send_random(input t_mix mix);
        int          add_w;
        int          del_w;
        int          nop_w;
        int          dup_w;
        int          r;
        int          k;
        int          idx;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic [31:0] host;
        t_prefix     p;
        case (mix)
            MIX_FILL:  begin add_w = 92; del_w = 3;  nop_w = 1; dup_w = 10; end
            MIX_DRAIN: begin add_w = 5;  del_w = 75; nop_w = 2; dup_w = 20; end
            default:   begin add_w = 35; del_w = 25; nop_w = 5; dup_w = 20; end
        endcase
        r    = $urandom_range(0, 99);
        k    = $urandom_range(0, 99);
        addr = $urandom;
        plen = 6'($urandom);
        if (r < add_w) begin
            op = OP_ADD;
            if (k < 5) begin
                plen = 6'($urandom_range(33, 63));
            end else if (k < 5 + dup_w && issued_prefixes.size() > 0) begin
                p    = issued_prefixes[$urandom_range(0, issued_prefixes.size() - 1)];
                addr = p.base;
                plen = p.plen;
            end else begin
                plen   = 6'($urandom_range(0, ADDR_BITS));
                p.base = addr;
                p.plen = plen;
                issued_prefixes.push_back(p);
                if (issued_prefixes.size() > 160) begin
                    void'(issued_prefixes.pop_front());
                end
            end
        end else if (r < add_w + del_w) begin
            op = OP_DEL;
            if (k < 70 && issued_prefixes.size() > 0) begin
                idx  = $urandom_range(0, issued_prefixes.size() - 1);
                addr = issued_prefixes[idx].base;
                plen = issued_prefixes[idx].plen;
                issued_prefixes.delete(idx);
            end else if (k < 85) begin
                plen = 6'($urandom_range(33, 63));
            end else begin
                plen = 6'($urandom_range(0, ADDR_BITS));
            end
        end else if (r < 100 - nop_w) begin
            op = OP_CHK;
            if (k < 65 && issued_prefixes.size() > 0) begin
                p = issued_prefixes[$urandom_range(0, issued_prefixes.size() - 1)];
                // Keep the prefix bits and randomize the host bits.
                host = (p.plen >= 6'(ADDR_BITS)) ? 32'h0 : (32'hFFFF_FFFF >> p.plen);
                addr = (p.base & ~host) | (addr & host);
                // Sometimes break one prefix bit to force a near miss.
                if (k < 15 && p.plen > 6'd0) begin
                    addr = addr ^ (32'h8000_0000 >> $urandom_range(0, p.plen - 1));
                end
            end
        end else begin
            op = OP_NOP;
        end
        send_item(op, addr, plen);
    endtask

    // One phase of random traffic. Bursts alternate between filling the
    // table past full, a balanced mix and draining it, so that the full
    // status and an emptied table both recur.
    task automatic run_phase(input int items, input int idle_pct);
        t_mix mix;
        sender_idle_pct = idle_pct;
        mix = MIX_FILL;
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) begin
                case ((i / 40) % 5)
                    0, 1:    mix = MIX_FILL;
                    2:       mix = MIX_BALANCED;
                    3:       mix = MIX_DRAIN;
                    default: mix = t_mix'($urandom_range(0, 2));
                endcase
            end
            send_random(mix);
            // Now and then the sender waits for every answer mid-phase.
            if ($urandom_range(0, 99) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items on an empty table first.
        sender_idle_pct = 15;
        send_item(OP_CHK, 32'h0000_0000, 6'd0);   // check with nothing stored
        send_item(OP_ADD, 32'h0000_0000, 6'd0);   // default route
        send_item(OP_CHK, 32'hFFFF_FFFF, 6'd0);   // zero length matches anything
        send_item(OP_ADD, 32'hFFFF_FFFF, 6'd32);  // full host route
        send_item(OP_CHK, 32'hFFFF_FFFF, 6'd63);  // longest match wins
        send_item(OP_CHK, 32'hFFFF_FFFE, 6'd0);   // last bit differs
        send_item(OP_ADD, 32'hFFFF_FFFF, 6'd32);  // duplicate pair
        send_item(OP_ADD, 32'hFFFF_FFFF, 6'd33);  // length just too long
        send_item(OP_ADD, 32'h0000_0000, 6'd63);  // length far too long
        send_item(OP_DEL, 32'hFFFF_FFFF, 6'd63);  // delete with bad length
        send_item(OP_ADD, 32'h0A00_0001, 6'd8);   // host bits are kept
        send_item(OP_ADD, 32'h0A00_0000, 6'd8);   // so this is a distinct entry
        send_item(OP_CHK, 32'h0AFF_FFFF, 6'd0);
        send_item(OP_ADD, 32'h0A80_0000, 6'd9);   // nested, longer prefix
        send_item(OP_CHK, 32'h0A81_2345, 6'd0);
        send_item(OP_DEL, 32'h0A00_0001, 6'd8);
        send_item(OP_DEL, 32'h0A00_0001, 6'd8);   // already gone
        send_item(OP_NOP, 32'hFFFF_FFFF, 6'd63);  // unknown opcode
        send_item(OP_NOP, 32'h0000_0000, 6'd0);
        send_item(OP_DEL, 32'h0000_0000, 6'd0);
        send_item(OP_CHK, 32'h1234_5678, 6'd0);   // no prefix covers this
        send_item(OP_DEL, 32'hFFFF_FFFF, 6'd32);
        send_item(OP_CHK, 32'hFFFF_FFFF, 6'd0);
        wait_drained();

        // Random traffic: light sender gaps, heavy gaps, then back to back.
        run_phase(300, 15);
        run_phase(300, 45);
        run_phase(250, 0);

        sb.report_leftovers();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* longest_prefix_match_table_unit.f */
rtl/lpmt_pkg.sv
rtl/lpmt_ctrl.sv
rtl/lpmt_dp.sv
rtl/longest_prefix_match_table_unit.sv
sim/testbench.sv
